/* rtl/pgm_pkg.sv */
// Shared constants and controller/datapath interface types for the Prewitt magnitude block.
package pgm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int LB_AW      = $clog2(MAX_WIDTH);

    localparam int PIX_W  = 8;
    localparam int ROW_W  = 12;
    localparam int COL_W  = 10;
    localparam int WID_W  = 11;
    localparam int HGT_W  = 13;
    localparam int CIDX_W = 4;
    localparam int CDAT_W = 16;

    localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    localparam logic [WID_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [PIX_W-1:0] SAT_LEVEL    = 8'd255;

    localparam int ROOT_STEPS = 8;
    localparam int STEP_W     = $clog2(ROOT_STEPS);

    typedef struct packed {
        logic              load;
        logic              calc;
        logic              square;
        logic              sum;
        logic              root;
        logic [STEP_W-1:0] step;
        logic              out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic interior;
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/pgm_ctrl.sv */
// Sequencer for one pixel word: gradient, then for interior pixels square, sum, square-root steps, output load.
module pgm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pgm_pkg::dp_status_t status,
    output pgm_pkg::ctrl_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CALC   = 3'd1;
    localparam logic [2:0] ST_SQUARE = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_ROOT   = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]                   state_reg, state_next;
    logic [pgm_pkg::STEP_W-1:0]   step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CALC;
                end
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = status.interior ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE: begin
                cmd.square = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                step_next  = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                cmd.root  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == pgm_pkg::STEP_W'(pgm_pkg::ROOT_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/pgm_datapath.sv */
// Line buffers, 3x3 window, position counters, gradient arithmetic, root unit and output register.
module pgm_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [pgm_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [pgm_pkg::CDAT_W-1:0]    cfg_data,
    input  logic [pgm_pkg::PIX_W-1:0]     s_pixel,
    input  pgm_pkg::ctrl_cmd_t            cmd,
    output pgm_pkg::dp_status_t           status,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pgm_pkg::PIX_W-1:0]     m_magnitude,
    output logic [pgm_pkg::ROW_W-1:0]     m_out_row,
    output logic [pgm_pkg::COL_W-1:0]     m_out_col,
    output logic                          m_last
);

    logic [pgm_pkg::PIX_W-1:0] older_mem [pgm_pkg::MAX_WIDTH];
    logic [pgm_pkg::PIX_W-1:0] newer_mem [pgm_pkg::MAX_WIDTH];
    logic [pgm_pkg::PIX_W-1:0] top_rd_reg, mid_rd_reg;
    logic [pgm_pkg::PIX_W-1:0] win_reg [6];

    logic [pgm_pkg::WID_W-1:0] width_reg;
    logic [pgm_pkg::HGT_W-1:0] height_reg;
    logic [pgm_pkg::WID_W-1:0] width_used;
    logic [pgm_pkg::HGT_W-1:0] height_used;

    logic [pgm_pkg::COL_W-1:0] col_cnt_reg;
    logic [pgm_pkg::ROW_W-1:0] row_cnt_reg;
    logic                      col_end, row_end;

    logic [pgm_pkg::PIX_W-1:0] pix_reg;
    logic [pgm_pkg::COL_W-1:0] col_reg;
    logic [pgm_pkg::ROW_W-1:0] row_reg;
    logic                      interior_reg, last_reg;

    logic [9:0]         left_sum, right_sum, upper_sum, lower_sum;
    logic signed [10:0] gx_next, gy_next;
    logic signed [10:0] gx_reg, gy_reg;
    logic [19:0]        sqx_reg, sqy_reg;
    logic signed [21:0] gx_prod, gy_prod;
    logic [20:0]        sq_sum;
    logic               sat_reg;

    logic [15:0] rem_reg, root_reg;
    logic [15:0] root_bit;
    logic [16:0] trial;

    logic m_valid_reg;
    logic [pgm_pkg::PIX_W-1:0] mag_reg;
    logic [pgm_pkg::ROW_W-1:0] out_row_reg;
    logic [pgm_pkg::COL_W-1:0] out_col_reg;
    logic                      out_last_reg;

    always_comb begin
        width_used = width_reg;
        if (width_reg < pgm_pkg::WID_W'(3)) begin
            width_used = pgm_pkg::WID_W'(3);
        end else if (width_reg > pgm_pkg::WID_W'(pgm_pkg::MAX_WIDTH)) begin
            width_used = pgm_pkg::WID_W'(pgm_pkg::MAX_WIDTH);
        end
        height_used = height_reg;
        if (height_reg < pgm_pkg::HGT_W'(3)) begin
            height_used = pgm_pkg::HGT_W'(3);
        end else if (height_reg > pgm_pkg::HGT_W'(pgm_pkg::MAX_HEIGHT)) begin
            height_used = pgm_pkg::HGT_W'(pgm_pkg::MAX_HEIGHT);
        end
    end

    assign col_end = ({1'b0, col_cnt_reg} + 1'b1) >= width_used;
    assign row_end = ({1'b0, row_cnt_reg} + 1'b1) >= height_used;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= pgm_pkg::WIDTH_RESET;
            height_reg  <= pgm_pkg::HEIGHT_RESET;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (cfg_valid) begin
            if (cfg_index == pgm_pkg::REG_IMAGE_WIDTH) begin
                width_reg   <= cfg_data[pgm_pkg::WID_W-1:0];
                col_cnt_reg <= '0;
                row_cnt_reg <= '0;
            end else if (cfg_index == pgm_pkg::REG_IMAGE_HEIGHT) begin
                height_reg  <= cfg_data[pgm_pkg::HGT_W-1:0];
                col_cnt_reg <= '0;
                row_cnt_reg <= '0;
            end
        end else if (cmd.load) begin
            if (col_end) begin
                col_cnt_reg <= '0;
                row_cnt_reg <= row_end ? '0 : row_cnt_reg + 1'b1;
            end else begin
                col_cnt_reg <= col_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pix_reg      <= s_pixel;
            col_reg      <= col_cnt_reg;
            row_reg      <= row_cnt_reg;
            interior_reg <= (row_cnt_reg >= pgm_pkg::ROW_W'(2))
                            && (col_cnt_reg >= pgm_pkg::COL_W'(2));
            last_reg     <= row_end && col_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            top_rd_reg <= older_mem[col_cnt_reg[pgm_pkg::LB_AW-1:0]];
            mid_rd_reg <= newer_mem[col_cnt_reg[pgm_pkg::LB_AW-1:0]];
        end
        if (cmd.calc) begin
            older_mem[col_reg[pgm_pkg::LB_AW-1:0]] <= mid_rd_reg;
            newer_mem[col_reg[pgm_pkg::LB_AW-1:0]] <= pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (cmd.calc) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_rd_reg;
            win_reg[4] <= mid_rd_reg;
            win_reg[5] <= pix_reg;
        end
    end

    assign left_sum  = 10'(win_reg[0]) + 10'(win_reg[1]) + 10'(win_reg[2]);
    assign right_sum = 10'(top_rd_reg) + 10'(mid_rd_reg) + 10'(pix_reg);
    assign upper_sum = 10'(win_reg[0]) + 10'(win_reg[3]) + 10'(top_rd_reg);
    assign lower_sum = 10'(win_reg[2]) + 10'(win_reg[5]) + 10'(pix_reg);
    assign gx_next   = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    assign gy_next   = $signed({1'b0, lower_sum}) - $signed({1'b0, upper_sum});
    assign gx_prod   = gx_reg * gx_reg;
    assign gy_prod   = gy_reg * gy_reg;
    assign sq_sum    = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    assign root_bit = 16'h4000 >> {cmd.step, 1'b0};
    assign trial    = {1'b0, root_reg} + {1'b0, root_bit};

    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            gx_reg <= gx_next;
            gy_reg <= gy_next;
        end
        if (cmd.square) begin
            sqx_reg <= gx_prod[19:0];
            sqy_reg <= gy_prod[19:0];
        end
        if (cmd.sum) begin
            sat_reg  <= |sq_sum[20:16];
            rem_reg  <= sq_sum[15:0];
            root_reg <= '0;
        end else if (cmd.root) begin
            if ({1'b0, rem_reg} >= trial) begin
                rem_reg  <= rem_reg - trial[15:0];
                root_reg <= (root_reg >> 1) + root_bit;
            end else begin
                root_reg <= root_reg >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            mag_reg      <= sat_reg ? pgm_pkg::SAT_LEVEL : root_reg[pgm_pkg::PIX_W-1:0];
            out_row_reg  <= row_reg - 1'b1;
            out_col_reg  <= col_reg - 1'b1;
            out_last_reg <= last_reg;
        end
    end

    assign status.interior = interior_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid     = m_valid_reg;
    assign m_magnitude = mag_reg;
    assign m_out_row   = out_row_reg;
    assign m_out_col   = out_col_reg;
    assign m_last      = out_last_reg;

endmodule

/* rtl/prewitt_gradient_magnitude.sv */
// Top level of the 3x3 Prewitt gradient magnitude block: controller plus datapath.
// An interior pixel word passes the gradient, square, sum, square-root and output-load states before m_valid.
// A new pixel word is taken only once the last one is done; a border pixel returns after the gradient,
// while an interior pixel also runs the eight square-root iterations of the shared root unit.
// A finished result waits in the output register while the next pixel word is taken.
// Reset: counters, window and size registers (640 x 480) clear; line buffers are not cleared.
module prewitt_gradient_magnitude (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pgm_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [pgm_pkg::CDAT_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pgm_pkg::PIX_W-1:0]     s_pixel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pgm_pkg::PIX_W-1:0]     m_magnitude,
    output logic [pgm_pkg::ROW_W-1:0]     m_out_row,
    output logic [pgm_pkg::COL_W-1:0]     m_out_col,
    output logic                          m_last
);

    pgm_pkg::ctrl_cmd_t  cmd;
    pgm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    pgm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pgm_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_pixel     (s_pixel),
        .cmd         (cmd),
        .status      (status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_magnitude (m_magnitude),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_last      (m_last)
    );

    a_one_word_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("pixel word taken while another is in work");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("output register loaded while a result still waits");

    a_interior_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_out_row != '0) && (m_out_col != '0))
        else $error("result delivered for a border position");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the streaming 3x3 Prewitt gradient magnitude block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pgm_pkg::CIDX_W-1:0] REG_UNUSED = 4'hF;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int SQ_SAT       = 65536;

    typedef struct packed {
        logic [pgm_pkg::PIX_W-1:0] magnitude;
        logic [pgm_pkg::ROW_W-1:0] row;
        logic [pgm_pkg::COL_W-1:0] col;
        logic                      last;
    } grad_result_t;

    typedef struct packed {
        logic                       is_cfg;
        logic [pgm_pkg::CIDX_W-1:0] index;
        logic [pgm_pkg::CDAT_W-1:0] data;
        logic [pgm_pkg::PIX_W-1:0]  pixel;
        logic                       typed;
        grad_result_t               want;
    } stim_row_t;

    localparam grad_result_t NO_RESULT = '0;
    localparam int DIRECTED_LEN = 30;

    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{1'b1, pgm_pkg::REG_IMAGE_WIDTH,  16'd3, 8'd0, 1'b0, NO_RESULT},
        '{1'b1, pgm_pkg::REG_IMAGE_HEIGHT, 16'd3, 8'd0, 1'b0, NO_RESULT},
        // flat frame of full-scale pixels
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b1, '{8'd0, 12'd1, 10'd1, 1'b1}},
        // vertical step edge, saturates
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd255, 1'b1, '{8'd255, 12'd1, 10'd1, 1'b1}},
        // single unit corner, unknown register write mid-frame
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b1, REG_UNUSED, 16'd5, 8'd0, 1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd0,   1'b0, NO_RESULT},
        '{1'b0, '0, '0, 8'd1,   1'b1, '{8'd1, 12'd1, 10'd1, 1'b1}}
    };

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [pgm_pkg::CIDX_W-1:0] cfg_index = '0;
    logic [pgm_pkg::CDAT_W-1:0] cfg_data  = '0;
    logic                       s_valid   = 1'b0;
    logic                       s_ready;
    logic [pgm_pkg::PIX_W-1:0]  s_pixel   = '0;
    logic                       m_valid;
    logic                       m_ready   = 1'b0;
    logic [pgm_pkg::PIX_W-1:0]  m_magnitude;
    logic [pgm_pkg::ROW_W-1:0]  m_out_row;
    logic [pgm_pkg::COL_W-1:0]  m_out_col;
    logic                       m_last;

    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int cycle_count    = 0;
    bit hold_done      = 1'b0;

    grad_result_t grad_pending [$];

    logic [pgm_pkg::PIX_W-1:0] older_line [pgm_pkg::MAX_WIDTH];
    logic [pgm_pkg::PIX_W-1:0] newer_line [pgm_pkg::MAX_WIDTH];
    logic [pgm_pkg::PIX_W-1:0] win_cols [6];
    int unsigned               pred_col    = 0;
    int unsigned               pred_row    = 0;
    logic [pgm_pkg::WID_W-1:0] pred_width  = pgm_pkg::WIDTH_RESET;
    logic [pgm_pkg::HGT_W-1:0] pred_height = pgm_pkg::HEIGHT_RESET;

    always #5 aclk = ~aclk;

    prewitt_gradient_magnitude u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_magnitude (m_magnitude),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_last      (m_last)
    );

    function automatic bit predict_gradient(input logic [pgm_pkg::PIX_W-1:0] pix,
                                            output grad_result_t res);
        int unsigned w, h, c, r, top, mid, p;
        int left, right, upper, lower, gx, gy, sq, mag, trial;
        bit made;
        w = (pred_width < 3) ? 3 :
            (pred_width > pgm_pkg::MAX_WIDTH) ? pgm_pkg::MAX_WIDTH : pred_width;
        h = (pred_height < 3) ? 3 :
            (pred_height > pgm_pkg::MAX_HEIGHT) ? pgm_pkg::MAX_HEIGHT : pred_height;
        c = pred_col;
        r = pred_row;
        top = older_line[c];
        mid = newer_line[c];
        p = pix;
        made = (r >= 2 && c >= 2);
        res = '0;
        if (made) begin
            left  = win_cols[0] + win_cols[1] + win_cols[2];
            right = top + mid + p;
            upper = win_cols[0] + win_cols[3] + top;
            lower = win_cols[2] + win_cols[5] + p;
            gx = right - left;
            gy = lower - upper;
            sq = gx * gx + gy * gy;
            if (sq >= SQ_SAT) begin
                mag = pgm_pkg::SAT_LEVEL;
            end else begin
                mag = 0;
                for (int b = pgm_pkg::PIX_W - 1; b >= 0; b--) begin
                    trial = mag | (1 << b);
                    if (trial * trial <= sq) mag = trial;
                end
            end
            res.magnitude = mag[pgm_pkg::PIX_W-1:0];
            res.row       = pgm_pkg::ROW_W'(r - 1);
            res.col       = pgm_pkg::COL_W'(c - 1);
            res.last      = (r + 1 >= h) && (c + 1 >= w);
        end
        older_line[c] = pgm_pkg::PIX_W'(mid);
        newer_line[c] = pgm_pkg::PIX_W'(p);
        win_cols[0] = win_cols[3];
        win_cols[1] = win_cols[4];
        win_cols[2] = win_cols[5];
        win_cols[3] = pgm_pkg::PIX_W'(top);
        win_cols[4] = pgm_pkg::PIX_W'(mid);
        win_cols[5] = pgm_pkg::PIX_W'(p);
        if (c + 1 >= w) begin
            pred_col = 0;
            pred_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            pred_col = c + 1;
        end
        return made;
    endfunction

    function automatic void apply_frame_size(input logic [pgm_pkg::CIDX_W-1:0] idx,
                                             input logic [pgm_pkg::CDAT_W-1:0] data);
        case (idx)
            pgm_pkg::REG_IMAGE_WIDTH: begin
                pred_width = data[pgm_pkg::WID_W-1:0];
                pred_col = 0;
                pred_row = 0;
            end
            pgm_pkg::REG_IMAGE_HEIGHT: begin
                pred_height = data[pgm_pkg::HGT_W-1:0];
                pred_col = 0;
                pred_row = 0;
            end
            default: ;
        endcase
    endfunction

    task automatic send_pixel(input logic [pgm_pkg::PIX_W-1:0] pix, input bit typed,
                              input grad_result_t want);
        grad_result_t predicted;
        bit made;
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= pix;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        made = predict_gradient(pix, predicted);
        if (typed) grad_pending.push_back(want);
        else if (made) grad_pending.push_back(predicted);
    endtask

    task automatic write_reg(input logic [pgm_pkg::CIDX_W-1:0] idx,
                             input logic [pgm_pkg::CDAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        apply_frame_size(idx, data);
    endtask

    // hold off until the block has gone quiet
    task automatic drain_results();
        s_valid <= 1'b0;
        while (grad_pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic run_segment(input int items);
        int sent, burst, which;
        sent = 0;
        while (sent < items) begin
            which = $urandom_range(2);
            if (which != 2) begin
                drain_results();
                write_reg(pgm_pkg::REG_IMAGE_WIDTH, {5'($urandom), 11'($urandom_range(9))});
            end
            if (which != 1) begin
                drain_results();
                write_reg(pgm_pkg::REG_IMAGE_HEIGHT, {3'($urandom), 13'($urandom_range(7))});
            end
            burst = $urandom_range(60, 8);
            repeat (burst) begin
                if (!hold_done && sent == items / 2) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (grad_pending.size() != 0) @(posedge aclk);
                    hold_done = 1'b1;
                end
                send_pixel(pgm_pkg::PIX_W'($urandom), 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge aclk) begin
        grad_result_t got, want;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (m_valid && m_ready) begin
            got = '{m_magnitude, m_out_row, m_out_col, m_last};
            if (grad_pending.size() == 0) begin
                $display("%0t: unexpected word mag=%0d row=%0d col=%0d last=%0b",
                         $time, got.magnitude, got.row, got.col, got.last);
                error_count++;
            end else begin
                want = grad_pending.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected mag=%0d row=%0d col=%0d last=%0b",
                             $time, want.magnitude, want.row, want.col, want.last);
                    $display("%0t:          actual   mag=%0d row=%0d col=%0d last=%0b",
                             $time, got.magnitude, got.row, got.col, got.last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < pgm_pkg::MAX_WIDTH; i++) begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        for (int i = 0; i < 6; i++) win_cols[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_gap_pct   = 21;
        recv_stall_pct = 88;
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            if (DIRECTED_ROWS[i].is_cfg) begin
                drain_results();
                write_reg(DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].data);
            end else begin
                send_pixel(DIRECTED_ROWS[i].pixel, DIRECTED_ROWS[i].typed,
                           DIRECTED_ROWS[i].want);
            end
        end
        run_segment(180);

        send_gap_pct   = 88;
        recv_stall_pct = 21;
        run_segment(180);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        run_segment(170);

        // widest frame, head of the top row
        drain_results();
        write_reg(pgm_pkg::REG_IMAGE_WIDTH, 16'hFFFF);
        drain_results();
        write_reg(pgm_pkg::REG_IMAGE_HEIGHT, {3'($urandom), 13'd3});
        repeat (40) send_pixel(pgm_pkg::PIX_W'($urandom), 1'b0, '0);

        // tallest frame, first rows
        drain_results();
        write_reg(pgm_pkg::REG_IMAGE_WIDTH, {5'($urandom), 11'd3});
        drain_results();
        write_reg(pgm_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
        repeat (30) send_pixel(pgm_pkg::PIX_W'($urandom), 1'b0, '0);

        drain_results();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
